### rtl/pulse_period_tachometer_defines.svh
// assertion macros used by ppt_ctrl in the tachometer rtl
// no dependencies; include by bare file name
`ifndef PULSE_PERIOD_TACHOMETER_DEFINES_SVH
`define PULSE_PERIOD_TACHOMETER_DEFINES_SVH

// clocked assertion, off while reset is asserted
`define PPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ppt_pkg.sv
// types and constants for the pulse period tachometer
// no dependencies
`timescale 1ns / 1ps

package ppt_pkg;

  localparam int unsigned SPEED_W = 25;
  localparam int unsigned DIV_W   = 26;
  localparam int unsigned CAP_W   = 16;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned PPR_W   = 8;

  localparam logic [DIV_W-1:0]   US_PER_MINUTE = 26'd60000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX     = 25'd30000000;

  localparam logic [TIME_W-1:0] OVF_TIME_RESET = 16'd50;
  localparam logic [PPR_W-1:0]  PPR_RESET      = 8'd2;
  localparam logic [TIME_W-1:0] STOP_TO_RESET  = 16'd2;

  localparam logic [1:0] CFG_OVF_TIME = 2'd0;
  localparam logic [1:0] CFG_PPR      = 2'd1;
  localparam logic [1:0] CFG_STOP_TO  = 2'd2;

  typedef enum logic [1:0] {
    MODE_OVF   = 2'd0,
    MODE_EDGE  = 2'd1,
    MODE_REARM = 2'd2,
    MODE_STOP  = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e             mode;
    logic [CAP_W-1:0]  capture_value;
    logic [TIME_W-1:0] elapsed;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_rpm;
    logic               measuring;
    logic               stopped;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic calc_period;
    logic calc_scale;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic meas_start;
    logic div_done;
    logic out_free;
  } ctrl_status_t;

endpackage

### rtl/ppt_divider.sv
// iterative restoring divider, one quotient bit per cycle
// depends on ppt_pkg
`timescale 1ns / 1ps

module ppt_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ppt_pkg::DIV_W-1:0] dividend_i,
  input  logic [ppt_pkg::DIV_W-1:0] divisor_i,
  output logic [ppt_pkg::DIV_W-1:0] quotient_o,
  output logic                      done_o
);

  localparam int unsigned CW = $clog2(ppt_pkg::DIV_W);

  logic [ppt_pkg::DIV_W-1:0] quo_q, quo_d;
  logic [ppt_pkg::DIV_W-1:0] rem_q, rem_d;
  logic [ppt_pkg::DIV_W-1:0] dvs_q, dvs_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [ppt_pkg::DIV_W:0]   rem_sh;
  logic [ppt_pkg::DIV_W:0]   rem_sub;

  assign rem_sh  = {rem_q, quo_q[ppt_pkg::DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      // trial subtract, keep the difference when it does not borrow
      if (!rem_sub[ppt_pkg::DIV_W]) begin
        rem_d = rem_sub[ppt_pkg::DIV_W-1:0];
        quo_d = {quo_q[ppt_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[ppt_pkg::DIV_W-1:0];
        quo_d = {quo_q[ppt_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(ppt_pkg::DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

### rtl/ppt_datapath.sv
// tachometer state, config registers, period arithmetic and output register
// depends on ppt_pkg and ppt_divider
`timescale 1ns / 1ps

module ppt_datapath #(
  parameter int unsigned OVERFLOW_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ppt_pkg::TIME_W-1:0] cfg_data_i,
  input  ppt_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ppt_pkg::out_item_t         out_data_o,
  input  ppt_pkg::ctrl_cmd_t         cmd_i,
  output ppt_pkg::ctrl_status_t      status_o
);

  localparam int unsigned PW  = OVERFLOW_BITS + ppt_pkg::TIME_W + 1;
  localparam int unsigned PWX = (PW > ppt_pkg::DIV_W) ? PW : ppt_pkg::DIV_W + 1;
  localparam int unsigned MW  = OVERFLOW_BITS + ppt_pkg::TIME_W;
  localparam int unsigned SW  = ppt_pkg::DIV_W + ppt_pkg::PPR_W;

  logic [ppt_pkg::TIME_W-1:0]  ovf_time_q;
  logic [ppt_pkg::PPR_W-1:0]   ppr_q;
  logic [ppt_pkg::TIME_W-1:0]  stop_to_q;

  logic [OVERFLOW_BITS-1:0]    ovf_cnt_q, ovf_cnt_d;
  logic                        first_q, first_d;
  logic                        meas_done_q, meas_done_d;
  logic                        counting_q, counting_d;
  logic [ppt_pkg::TIME_W-1:0]  timeout_q, timeout_d;
  logic [ppt_pkg::SPEED_W-1:0] speed_q, speed_d;
  logic                        out_valid_q;
  ppt_pkg::out_item_t          out_q;

  logic [ppt_pkg::CAP_W-1:0]   cap_q;
  logic [PW-1:0]               period_q;
  logic                        zero_q;
  logic                        big_q;
  logic                        div_wr_q;

  logic [MW-1:0]               product;
  logic [PWX-1:0]              period_x;
  logic [ppt_pkg::PPR_W-1:0]   ppr_eff;
  logic [SW-1:0]               denom_full;
  logic [ppt_pkg::DIV_W-1:0]   quotient;
  logic                        div_done;
  logic [ppt_pkg::TIME_W-1:0]  to_left;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_time_q <= ppt_pkg::OVF_TIME_RESET;
      ppr_q      <= ppt_pkg::PPR_RESET;
      stop_to_q  <= ppt_pkg::STOP_TO_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppt_pkg::CFG_OVF_TIME: ovf_time_q <= cfg_data_i;
        ppt_pkg::CFG_PPR:      ppr_q      <= cfg_data_i[ppt_pkg::PPR_W-1:0];
        ppt_pkg::CFG_STOP_TO:  stop_to_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-item state update and the write of the division result
  always_comb begin
    ovf_cnt_d   = ovf_cnt_q;
    first_d     = first_q;
    meas_done_d = meas_done_q;
    counting_d  = counting_q;
    timeout_d   = timeout_q;
    speed_d     = speed_q;
    to_left     = (in_data_i.elapsed >= timeout_q) ? '0 : timeout_q - in_data_i.elapsed;
    if (cmd_i.accept) begin
      case (in_data_i.mode)
        ppt_pkg::MODE_OVF: begin
          if (counting_q) ovf_cnt_d = ovf_cnt_q + 1'b1;
        end
        ppt_pkg::MODE_EDGE: begin
          if (!meas_done_q) begin
            timeout_d = stop_to_q;
            if (first_q) begin
              meas_done_d = 1'b1;
              first_d     = 1'b0;
              counting_d  = 1'b0;
            end else begin
              ovf_cnt_d  = '0;
              first_d    = 1'b1;
              counting_d = 1'b1;
            end
          end
        end
        ppt_pkg::MODE_REARM: begin
          if (meas_done_q) begin
            meas_done_d = 1'b0;
            ovf_cnt_d   = '0;
          end
        end
        ppt_pkg::MODE_STOP: begin
          if (timeout_q != '0) timeout_d = to_left;
          if (timeout_d == '0) speed_d = '0;
        end
        default: ;
      endcase
    end else if (status_o.div_done) begin
      // result of the measurement, saturated at both ends
      if (zero_q) begin
        speed_d = ppt_pkg::SPEED_MAX;
      end else if (big_q) begin
        speed_d = '0;
      end else if (quotient > ppt_pkg::DIV_W'(ppt_pkg::SPEED_MAX)) begin
        speed_d = ppt_pkg::SPEED_MAX;
      end else begin
        speed_d = quotient[ppt_pkg::SPEED_W-1:0];
      end
    end
  end

  // speed is written once per division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_wr_q <= 1'b0;
    end else if (cmd_i.calc_scale) begin
      div_wr_q <= 1'b1;
    end else if (div_done) begin
      div_wr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_cnt_q   <= '0;
      first_q     <= 1'b0;
      meas_done_q <= 1'b0;
      counting_q  <= 1'b0;
      timeout_q   <= '0;
      speed_q     <= '0;
    end else begin
      ovf_cnt_q   <= ovf_cnt_d;
      first_q     <= first_d;
      meas_done_q <= meas_done_d;
      counting_q  <= counting_d;
      timeout_q   <= timeout_d;
      speed_q     <= speed_d;
    end
  end

  // period = overflows * overflow time + capture, then scaled by pulses per rev
  assign product    = MW'(ovf_cnt_q) * MW'(ovf_time_q);
  assign period_x   = PWX'(period_q);
  assign ppr_eff    = (ppr_q == '0) ? ppt_pkg::PPR_W'(1) : ppr_q;
  assign denom_full = SW'(period_x[ppt_pkg::DIV_W-1:0]) * SW'(ppr_eff);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cap_q <= in_data_i.capture_value;
    if (cmd_i.calc_period) period_q <= PW'(product) + PW'(cap_q);
    if (cmd_i.calc_scale) begin
      zero_q <= (period_q == '0);
      big_q  <= (|period_x[PWX-1:ppt_pkg::DIV_W]) |
                (|denom_full[SW-1:ppt_pkg::DIV_W]);
    end
  end

  ppt_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.calc_scale),
    .dividend_i (ppt_pkg::US_PER_MINUTE),
    .divisor_i  (denom_full[ppt_pkg::DIV_W-1:0]),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.speed_rpm <= speed_q;
      out_q.measuring <= counting_q;
      out_q.stopped   <= (timeout_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign status_o.meas_start = (in_data_i.mode == ppt_pkg::MODE_EDGE) &&
                               !meas_done_q && first_q;
  assign status_o.div_done   = div_done && div_wr_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### rtl/ppt_ctrl.sv
// sequencing state machine for the tachometer
// depends on ppt_pkg and pulse_period_tachometer_defines.svh
`timescale 1ns / 1ps
`include "pulse_period_tachometer_defines.svh"

module ppt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ppt_pkg::ctrl_status_t status_i,
  output ppt_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PERIOD = 5'b00010,
    S_SCALE  = 5'b00100,
    S_DIV    = 5'b01000,
    S_LOAD   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d           = state_q;
    cmd_o.accept      = 1'b0;
    cmd_o.calc_period = 1'b0;
    cmd_o.calc_scale  = 1'b0;
    cmd_o.load_out    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.meas_start ? S_PERIOD : S_LOAD;
        end
      end
      S_PERIOD: begin
        cmd_o.calc_period = 1'b1;
        state_d           = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.calc_scale = 1'b1;
        state_d          = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_LOAD;
      end
      S_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PPT_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.load_out |-> status_i.out_free, "load into full output register")
  `PPT_ASSERT(a_meas_seq, clk_i, rst_ni, (accept && status_i.meas_start) |=> (state_q == S_PERIOD) ##1 (state_q == S_SCALE), "measurement sequence broken")
  `PPT_ASSERT(a_div_exit, clk_i, rst_ni, (state_q == S_DIV && status_i.div_done) |=> (state_q == S_LOAD), "divider finish not followed by load")
  `PPT_ASSERT_ALWAYS(a_no_accept_busy, clk_i, (state_q != S_IDLE) |-> !cmd_o.accept, "item taken while busy")

endmodule

### rtl/pulse_period_tachometer.sv
// top level of the pulse period tachometer
// depends on ppt_pkg, ppt_ctrl, ppt_datapath, ppt_divider
`timescale 1ns / 1ps

// Pulse period tachometer. Each input item (overflow tick, capture edge,
// re-arm check, stop-check tick) yields exactly one result item with the speed
// in rpm, the measuring flag and the stopped flag as they stand after that item.
// Items are taken one at a time. Ticks, re-arm checks and edges that do not
// close a measurement go from acceptance straight to the output load. The edge
// that closes a measurement passes through the period multiply-add, scaling
// by pulses per revolution, the restoring divider that forms 60000000 /
// (period * pulses per rev) one bit a cycle, and the output load. The output
// register lets the next item be accepted while a result still waits; a
// finished result waits in the controller only if the previous one has not
// yet been taken. Configuration is a plain write port (index 0 overflow time
// in us, 1 pulses per rev, 2 stop timeout); the user must write it only while
// idle, the block does not enforce this. No clearing pass is needed after reset.
module pulse_period_tachometer #(
  parameter int unsigned OVERFLOW_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [ppt_pkg::TIME_W-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ppt_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ppt_pkg::out_item_t         out_data_o
);

  // command and status between controller and datapath
  ppt_pkg::ctrl_cmd_t    cmd;
  ppt_pkg::ctrl_status_t status;

  ppt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // state, arithmetic and the output register
  ppt_datapath #(
    .OVERFLOW_BITS (OVERFLOW_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

### tb/ppt_checker.sv
// tachometer scoreboard: mirrors the speed measurement and checks every result item
// depends on ppt_pkg; watches the config port and both item channels
`timescale 1ns / 1ps

module ppt_checker import ppt_pkg::*; #(
  parameter int unsigned OVERFLOW_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [TIME_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       open_o
);

  // register mirror
  logic [TIME_W-1:0]        ovf_time_us;
  logic [PPR_W-1:0]         pulses_per_rev;
  logic [TIME_W-1:0]        stop_reload;

  // measurement mirror
  logic [OVERFLOW_BITS-1:0] ovf_count;
  logic                     armed;
  logic                     period_done;
  logic                     counting;
  logic [TIME_W-1:0]        timeout_left;
  logic [SPEED_W-1:0]       speed;

  out_item_t                speed_readings[$];
  int unsigned              results_seen;

  function automatic logic [SPEED_W-1:0] speed_from_period(longint unsigned period,
                                                           logic [PPR_W-1:0] ppr);
    longint unsigned per_minute;
    longint unsigned divisor;
    longint unsigned rpm;
    per_minute = 64'(US_PER_MINUTE);
    divisor = (ppr == '0) ? 64'd1 : 64'(ppr);
    if (period == 64'd0) return SPEED_MAX;
    rpm = (per_minute / period) / divisor;
    if (rpm > 64'(SPEED_MAX)) return SPEED_MAX;
    return rpm[SPEED_W-1:0];
  endfunction

  function automatic out_item_t step_tacho(in_item_t it);
    out_item_t       res;
    longint unsigned period;
    case (it.mode)
      MODE_OVF: begin
        if (counting) ovf_count = ovf_count + 1'b1;
      end
      MODE_EDGE: begin
        // edges between the closing edge and a re-arm do nothing at all
        if (!period_done) begin
          timeout_left = stop_reload;
          if (armed) begin
            period = 64'(ovf_count);
            period = period * 64'(ovf_time_us) + 64'(it.capture_value);
            speed = speed_from_period(period, pulses_per_rev);
            period_done = 1'b1;
            armed = 1'b0;
            counting = 1'b0;
          end else begin
            ovf_count = '0;
            armed = 1'b1;
            counting = 1'b1;
          end
        end
      end
      MODE_REARM: begin
        if (period_done) begin
          period_done = 1'b0;
          ovf_count = '0;
        end
      end
      default: begin
        if (timeout_left != '0)
          timeout_left = (it.elapsed >= timeout_left) ? '0 : timeout_left - it.elapsed;
        if (timeout_left == '0) speed = '0;
      end
    endcase
    res.speed_rpm = speed;
    res.measuring = counting;
    res.stopped = (timeout_left == '0);
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned seen,
                               input longint unsigned want);
    $display("mismatch on result %0d, %s: got %0d, expected %0d", results_seen, what,
             seen, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      ovf_time_us = OVF_TIME_RESET;
      pulses_per_rev = PPR_RESET;
      stop_reload = STOP_TO_RESET;
      ovf_count = '0;
      armed = 1'b0;
      period_done = 1'b0;
      counting = 1'b0;
      timeout_left = '0;
      speed = '0;
      speed_readings.delete();
      results_seen = 0;
      fail_count_o = 0;
    end else begin
      // a result never leaves in the cycle its item is taken, so compare first
      if (out_valid_i && out_ready_i) begin
        if (speed_readings.size() == 0) begin
          flag_mismatch("result with nothing outstanding", 64'(out_data_i.speed_rpm),
                        64'd0);
        end else begin
          want = speed_readings.pop_front();
          if (out_data_i.speed_rpm !== want.speed_rpm)
            flag_mismatch("speed_rpm", 64'(out_data_i.speed_rpm), 64'(want.speed_rpm));
          if (out_data_i.measuring !== want.measuring)
            flag_mismatch("measuring", 64'(out_data_i.measuring), 64'(want.measuring));
          if (out_data_i.stopped !== want.stopped)
            flag_mismatch("stopped", 64'(out_data_i.stopped), 64'(want.stopped));
        end
        results_seen++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OVF_TIME: ovf_time_us = cfg_data_i;
          CFG_PPR:      pulses_per_rev = cfg_data_i[PPR_W-1:0];
          CFG_STOP_TO:  stop_reload = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) speed_readings.push_back(step_tacho(in_data_i));
    end
    open_o = speed_readings.size();
  end

endmodule

### tb/pulse_period_tachometer_tb.sv
// testbench top for the pulse period tachometer: stimulus, stalls and verdict
// depends on ppt_pkg, pulse_period_tachometer and ppt_checker
`timescale 1ns / 1ps

module pulse_period_tachometer_tb;
  import ppt_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1050;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned TAIL_ITEMS    = 150;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  // slowest run: ~1.1k items that may each take a closing edge, an idle gap
  // and a receiver stall, plus the long hold-off
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = CFG_OVF_TIME;
  logic [TIME_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  int unsigned       sent = 0;
  int unsigned       got = 0;
  int unsigned       cycles = 0;
  int unsigned       fail_count;
  int unsigned       open_count;
  bit                quiet = 1'b0;      // no idling on either side
  bit                hold_long = 1'b0;  // asks the receiver for one long hold-off
  bit                hold_done = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pulse_period_tachometer #(
    .OVERFLOW_BITS(16)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ppt_checker #(
    .OVERFLOW_BITS(16)
  ) i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .open_o       (open_count)
  );

  // results taken so far
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) got <= got + 1;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_long && !hold_done) begin
        // long enough for the output register and the waiting slot to fill
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ready <= 1'b1;
    end
  end

  // random 16-bit field value
  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  function automatic in_item_t make_item(mode_e m, logic [CAP_W-1:0] cap,
                                         logic [TIME_W-1:0] el);
    in_item_t it;
    it.mode = m;
    it.capture_value = cap;
    it.elapsed = el;
    return it;
  endfunction

  // capture value: small ones give high speeds, full range covers every bit
  function automatic logic [CAP_W-1:0] pick_capture();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return CAP_W'($urandom_range(0, 255));
      default: return CAP_W'($urandom);
    endcase
  endfunction

  // elapsed: mostly small so the timeout drains over several ticks
  function automatic logic [TIME_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return TIME_W'($urandom);
      default: return TIME_W'($urandom_range(0, 20));
    endcase
  endfunction

  // offer one item, maybe after an idle burst, and wait for the handshake
  task automatic offer(input in_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sent++;
  endtask

  // stop offering until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    wait (got == sent);
    @(posedge clk_i);
  endtask

  // all three registers on consecutive edges; only while idle
  task automatic program_regs(input logic [TIME_W-1:0] ovf_us, input logic [PPR_W-1:0] ppr,
                              input logic [TIME_W-1:0] stop_to);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_OVF_TIME;
    cfg_data <= ovf_us;
    @(posedge clk_i);
    cfg_idx <= CFG_PPR;
    cfg_data <= TIME_W'(ppr);
    @(posedge clk_i);
    cfg_idx <= CFG_STOP_TO;
    cfg_data <= stop_to;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // one full measurement: re-arm, arming edge, ticks with stop checks mixed in,
  // closing edge, then a few stop checks
  task automatic run_measurement();
    int unsigned ticks;
    ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
    offer(make_item(MODE_REARM, rand16(), rand16()));
    offer(make_item(MODE_EDGE, pick_capture(), rand16()));
    repeat (ticks) begin
      if ($urandom_range(0, 5) == 0) offer(make_item(MODE_STOP, rand16(), pick_elapsed()));
      offer(make_item(MODE_OVF, rand16(), rand16()));
    end
    offer(make_item(MODE_EDGE, pick_capture(), rand16()));
    repeat ($urandom_range(0, 2)) offer(make_item(MODE_STOP, rand16(), pick_elapsed()));
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned quota;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one pulse per rev and 1 us overflows to reach the clamp
    program_regs(16'd1, 8'd1, 16'hFFFF);
    offer(make_item(MODE_OVF, rand16(), rand16()));      // tick while not armed
    offer(make_item(MODE_REARM, rand16(), rand16()));    // re-arm with nothing done
    offer(make_item(MODE_STOP, rand16(), 16'd0));        // timeout already zero
    offer(make_item(MODE_EDGE, 16'hFFFF, rand16()));     // arm
    offer(make_item(MODE_EDGE, 16'h0000, rand16()));     // zero period saturates
    offer(make_item(MODE_EDGE, 16'd5, rand16()));        // edge after done is ignored
    offer(make_item(MODE_REARM, rand16(), rand16()));
    offer(make_item(MODE_EDGE, rand16(), rand16()));
    offer(make_item(MODE_EDGE, 16'd1, rand16()));        // 1 us period, clamped
    offer(make_item(MODE_REARM, rand16(), rand16()));
    offer(make_item(MODE_EDGE, rand16(), rand16()));
    repeat (3) offer(make_item(MODE_OVF, rand16(), rand16()));
    offer(make_item(MODE_EDGE, 16'hFFFF, rand16()));
    offer(make_item(MODE_STOP, rand16(), 16'd1));
    offer(make_item(MODE_STOP, rand16(), 16'hFFFF));     // elapsed above timeout
    offer(make_item(MODE_STOP, rand16(), 16'd0));
    drain();

    // zero pulses per rev acts as one, longest overflow time, shortest timeout
    program_regs(16'hFFFF, 8'd0, 16'd1);
    offer(make_item(MODE_REARM, rand16(), rand16()));
    offer(make_item(MODE_EDGE, rand16(), rand16()));
    repeat (2) offer(make_item(MODE_OVF, rand16(), rand16()));
    offer(make_item(MODE_EDGE, 16'd12345, rand16()));
    offer(make_item(MODE_STOP, rand16(), 16'd0));
    offer(make_item(MODE_STOP, rand16(), 16'd1));        // elapsed equal to timeout
    drain();

    // random phases, each under its own register setting
    quota = RANDOM_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       program_regs(OVF_TIME_RESET, PPR_RESET, STOP_TO_RESET);
        1:       program_regs(16'hFFFF, 8'hFF, 16'hFFFF);
        2:       program_regs(16'd1, 8'd1, 16'd1);
        3:       program_regs(TIME_W'($urandom_range(1, 65535)),
                              PPR_W'($urandom_range(1, 255)),
                              TIME_W'($urandom_range(1, 300)));
        default: program_regs(TIME_W'($urandom_range(1, 1000)),
                              PPR_W'($urandom_range(1, 8)),
                              TIME_W'($urandom_range(1, 100)));
      endcase
      // sender keeps offering through the long hold-off so the input stalls
      if (ph == 1) hold_long <= 1'b1;
      phase_start = sent;
      while (sent - phase_start < quota) begin
        if (ph == PHASES - 1 && sent - phase_start >= quota - TAIL_ITEMS) quiet = 1'b1;
        if ($urandom_range(0, 5) == 0) begin
          // noise: any mode, any fields, out of sequence
          repeat ($urandom_range(1, 3))
            offer(make_item(mode_e'($urandom_range(0, 3)), rand16(), rand16()));
        end else begin
          run_measurement();
        end
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
